// ----- hdl/iprlf_pkg.sv -----
// Shared types, constants and helper functions for the IPv4 route lookup forwarding unit.
// Used by the route table, the checksum unit and the top level; depends on nothing.
package iprlf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int MAX_LEN  = 32;
  localparam int HDR_WORDS = 5;
  localparam int HDR_W    = 32 * HDR_WORDS;
  localparam int HW_W     = 16;
  localparam int HW_CNT   = HDR_W / HW_W;
  localparam int HW_CNT_W = $clog2(HW_CNT + 1);
  localparam int PADDR_W  = 3;

  localparam logic CFG_IDX_LOCAL = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_FORWARD = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_LOCAL    = 3'd0,
    STAT_FORWARD  = 3'd1,
    STAT_TTL_DROP = 3'd2,
    STAT_NO_ROUTE = 3'd3,
    STAT_ADDED    = 3'd4,
    STAT_FULL     = 3'd5,
    STAT_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CSUM,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] route_prefix;
    logic [5:0]  route_mask_len;
    logic [31:0] route_next_hop;
    logic [31:0] header_word_0;
    logic [31:0] header_word_1;
    logic [31:0] header_word_2;
    logic [31:0] header_word_3;
    logic [31:0] header_word_4;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] hop;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } tbl_ctrl_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ----- hdl/iprlf_route_mem.sv -----
// Route table storage: one write port and one registered read port.
// Depends on iprlf_pkg for the entry type and the table depth.
module iprlf_route_mem (
  input  logic                clk,
  input  iprlf_pkg::tbl_ctrl_t ctrl,
  input  iprlf_pkg::entry_t   wdata,
  output iprlf_pkg::entry_t   rdata
);

  iprlf_pkg::entry_t mem [iprlf_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.re) begin
      rdata <= mem[ctrl.raddr];
    end
  end

endmodule

// ----- hdl/iprlf_csum.sv -----
// Iterative IPv4 header checksum: one 16-bit word per cycle through a shared end-around adder.
// Depends on iprlf_pkg for the header and word widths.
module iprlf_csum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [iprlf_pkg::HDR_W-1:0]   hdr,
  output logic                          busy,
  output logic [iprlf_pkg::HW_W-1:0]    sum
);

  logic [iprlf_pkg::HDR_W-1:0]    shift;
  logic [iprlf_pkg::HW_W-1:0]     acc;
  logic [iprlf_pkg::HW_CNT_W-1:0] cnt;
  logic [iprlf_pkg::HW_W:0]       raw;
  logic [iprlf_pkg::HW_W-1:0]     acc_next;

  assign busy = (cnt != '0);
  assign raw = {1'b0, acc} + {1'b0, shift[iprlf_pkg::HDR_W-1 -: iprlf_pkg::HW_W]};
  assign acc_next = raw[iprlf_pkg::HW_W-1:0] + iprlf_pkg::HW_W'(raw[iprlf_pkg::HW_W]);
  assign sum = ~acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= iprlf_pkg::HW_CNT_W'(iprlf_pkg::HW_CNT);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= hdr;
      acc   <= '0;
    end else if (busy) begin
      shift <= shift << iprlf_pkg::HW_W;
      acc   <= acc_next;
    end
  end

endmodule

// ----- hdl/ipv4_route_lookup_forward_unit.sv -----
// Top level of the IPv4 route lookup forwarding unit: sequencer, table scan and APB registers.
// Depends on iprlf_pkg, iprlf_route_mem and iprlf_csum.
//
// Usage: a request on req (valid/ready) carries one command: clear the route
// table, add a route, or forward a packet given its 20-byte header. Each
// request except the unused command gives exactly one response on rsp.
// The local address is written through the APB port at byte address 0; the
// user must do so only while the unit is idle; the block does not enforce it.
// Clear, add, local delivery, TTL drop and lookups on an empty table go to the
// result state at once and raise rsp_valid when the output register is free.
// A forward scans the route table one entry per cycle through the single read
// port of the table memory and, if a route is found, waits for the header
// checksum, summed one 16-bit word at a time in a shared adder. req_ready is
// high only while no request is in progress, so a new request is taken only
// after the last result has moved into the output register.
// Reset empties the route table and clears the local address.
// A response that the receiver does not take waits in the output register;
// the unit meanwhile takes and works on the next request, and holds its
// result until the output register is free.
module ipv4_route_lookup_forward_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  iprlf_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output iprlf_pkg::rsp_t               rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iprlf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  iprlf_pkg::state_t    state;
  iprlf_pkg::state_t    state_next;
  iprlf_pkg::tbl_ctrl_t tbl_ctrl;
  iprlf_pkg::entry_t    tbl_wdata;
  iprlf_pkg::entry_t    tbl_rdata;
  iprlf_pkg::rsp_t      pend;

  logic [31:0]                 local_addr;
  logic [iprlf_pkg::CNT_W-1:0] count;
  logic [iprlf_pkg::CNT_W-1:0] scan;
  logic [31:0]                 dst;
  logic [7:0]                  work_ttl;
  logic                        cmp_valid;
  logic                        found;
  logic [iprlf_pkg::LEN_W-1:0] best_len;
  logic [31:0]                 best_hop;

  logic                        accept;
  logic                        issue;
  logic                        lookup_done;
  logic                        slot_free;
  logic                        full;
  logic                        quick_fwd;
  logic                        match;
  logic [7:0]                  ttl_in;
  logic [7:0]                  ttl_dec;
  logic                        csum_start;
  logic                        csum_busy;
  logic [iprlf_pkg::HW_W-1:0]  csum_value;
  logic [iprlf_pkg::HDR_W-1:0] csum_hdr;
  logic [iprlf_pkg::LEN_W-1:0] add_len;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == iprlf_pkg::CFG_IDX_LOCAL) ? local_addr : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == iprlf_pkg::CFG_IDX_LOCAL) begin
      local_addr <= pwdata;
    end
  end

  assign ttl_in    = req.header_word_2[31:24];
  assign ttl_dec   = ttl_in - 8'd1;
  assign full      = (count == iprlf_pkg::CNT_W'(iprlf_pkg::TABLE_DEPTH));
  assign quick_fwd = (req.header_word_4 == local_addr) || (ttl_in == 8'd0) || (count == '0);
  assign add_len   = (req.route_mask_len > iprlf_pkg::LEN_W'(iprlf_pkg::MAX_LEN))
                     ? iprlf_pkg::LEN_W'(iprlf_pkg::MAX_LEN) : req.route_mask_len;
  assign csum_hdr  = {req.header_word_0, req.header_word_1,
                      ttl_dec, req.header_word_2[23:16], 16'd0,
                      req.header_word_3, req.header_word_4};
  assign match = cmp_valid
                 && (((dst ^ tbl_rdata.prefix) & iprlf_pkg::prefix_mask(tbl_rdata.length)) == '0)
                 && (!found || tbl_rdata.length > best_len);

  always_comb begin
    state_next = state;
    unique case (state)
      iprlf_pkg::S_IDLE: begin
        if (accept) begin
          case (req.cmd) inside
            iprlf_pkg::CMD_CLEAR, iprlf_pkg::CMD_ADD: state_next = iprlf_pkg::S_RESULT;
            iprlf_pkg::CMD_FORWARD: begin
              state_next = quick_fwd ? iprlf_pkg::S_RESULT : iprlf_pkg::S_LOOKUP;
            end
            default: state_next = iprlf_pkg::S_IDLE;
          endcase
        end
      end
      iprlf_pkg::S_LOOKUP: begin
        if (lookup_done) begin
          state_next = found ? iprlf_pkg::S_CSUM : iprlf_pkg::S_RESULT;
        end
      end
      iprlf_pkg::S_CSUM: begin
        if (!csum_busy) begin
          state_next = iprlf_pkg::S_RESULT;
        end
      end
      iprlf_pkg::S_RESULT: begin
        if (slot_free) begin
          state_next = iprlf_pkg::S_IDLE;
        end
      end
      default: state_next = iprlf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready      = (state == iprlf_pkg::S_IDLE);
    accept         = req_valid && req_ready;
    issue          = (state == iprlf_pkg::S_LOOKUP) && (scan < count);
    lookup_done    = (state == iprlf_pkg::S_LOOKUP) && !issue && !cmp_valid;
    slot_free      = !rsp_valid || rsp_ready;
    csum_start     = accept && (req.cmd == iprlf_pkg::CMD_FORWARD);
    tbl_ctrl.we    = accept && (req.cmd == iprlf_pkg::CMD_ADD) && !full;
    tbl_ctrl.waddr = count[iprlf_pkg::IDX_W-1:0];
    tbl_ctrl.re    = issue;
    tbl_ctrl.raddr = scan[iprlf_pkg::IDX_W-1:0];
    tbl_wdata.prefix = req.route_prefix;
    tbl_wdata.length = add_len;
    tbl_wdata.hop    = req.route_next_hop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iprlf_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (accept && req.cmd == iprlf_pkg::CMD_CLEAR) begin
        count <= '0;
      end else if (tbl_ctrl.we) begin
        count <= count + 1'b1;
      end
      if (state == iprlf_pkg::S_RESULT && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == iprlf_pkg::S_RESULT && slot_free) begin
      rsp <= pend;
    end
    if (accept) begin
      pend.next_hop     <= '0;
      pend.new_ttl      <= '0;
      pend.new_checksum <= '0;
      dst      <= req.header_word_4;
      work_ttl <= ttl_dec;
      scan     <= '0;
      found    <= 1'b0;
      case (req.cmd)
        iprlf_pkg::CMD_CLEAR: pend.status <= iprlf_pkg::STAT_CLEARED;
        iprlf_pkg::CMD_ADD: pend.status <= full ? iprlf_pkg::STAT_FULL : iprlf_pkg::STAT_ADDED;
        default: begin
          if (req.header_word_4 == local_addr) begin
            pend.status <= iprlf_pkg::STAT_LOCAL;
          end else if (ttl_in == 8'd0) begin
            pend.status <= iprlf_pkg::STAT_TTL_DROP;
          end else begin
            pend.status <= iprlf_pkg::STAT_NO_ROUTE;
          end
        end
      endcase
    end else begin
      if (issue) begin
        scan <= scan + 1'b1;
      end
      if (match) begin
        found    <= 1'b1;
        best_len <= tbl_rdata.length;
        best_hop <= tbl_rdata.hop;
      end
      if (state == iprlf_pkg::S_CSUM && !csum_busy) begin
        pend.status       <= iprlf_pkg::STAT_FORWARD;
        pend.next_hop     <= best_hop;
        pend.new_ttl      <= work_ttl;
        pend.new_checksum <= csum_value;
      end
    end
  end

  iprlf_route_mem u_table (
    .clk   (clk),
    .ctrl  (tbl_ctrl),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  iprlf_csum u_csum (
    .clk   (clk),
    .rst   (rst),
    .start (csum_start),
    .hdr   (csum_hdr),
    .busy  (csum_busy),
    .sum   (csum_value)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= iprlf_pkg::CNT_W'(iprlf_pkg::TABLE_DEPTH))
    else $error("Route count exceeds the table depth.");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == iprlf_pkg::CMD_ADD && full) |=> $stable(count))
    else $error("A refused add changed the route count.");

  a_lookup_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == iprlf_pkg::S_LOOKUP) |-> (count != '0))
    else $error("Table scan started on an empty table.");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != iprlf_pkg::STAT_FORWARD)
      |-> (rsp.next_hop == '0 && rsp.new_ttl == '0 && rsp.new_checksum == '0))
    else $error("A response that is not a forward carries nonzero fields.");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for ipv4_route_lookup_forward_unit: directed table plus random phases,
// checked against a route lookup and checksum predictor. Depends on iprlf_pkg and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                   CMD_UNUSED    = 2'd3;
  localparam logic [iprlf_pkg::PADDR_W-1:0] LOCAL_OFS     =
    iprlf_pkg::PADDR_W'(iprlf_pkg::CFG_IDX_LOCAL) << 2;
  localparam int                           TARGET_REQS   = 1250;
  localparam int                           SETTLE_CYCLES = 80;
  localparam int                           HOLD_CYCLES   = 300;
  localparam int                           DRAIN_LIMIT   = 2000;

  typedef struct {
    iprlf_pkg::req_t r;
    bit              fixed;
    iprlf_pkg::rsp_t want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  iprlf_pkg::req_t               req = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  iprlf_pkg::rsp_t               rsp;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [iprlf_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predictor state.
  logic [31:0] rt_prefix [iprlf_pkg::TABLE_DEPTH];
  logic [5:0]  rt_len [iprlf_pkg::TABLE_DEPTH];
  logic [31:0] rt_hop [iprlf_pkg::TABLE_DEPTH];
  int          rt_count = 0;
  logic [31:0] node_addr = '0;

  iprlf_pkg::rsp_t route_results_due[$];
  dir_row_t        directed[$];
  bit              cur_fixed = 1'b0;
  iprlf_pkg::rsp_t cur_fixed_rsp = '0;
  bit              gaps_on = 1'b1;
  bit              hold_off_req = 1'b0;
  int              mismatches = 0;
  int              reqs_sent = 0;
  int              unused_sent = 0;
  int              status_seen [8] = '{default: 0};

  ipv4_route_lookup_forward_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] route_mask(input logic [5:0] len);
    route_mask = (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
  endfunction

  function automatic logic [15:0] header_checksum(input logic [31:0] w0, w1, w2, w3, w4);
    logic [31:0] s;
    s = w0[31:16] + w0[15:0] + w1[31:16] + w1[15:0] + w2[31:16] + w2[15:0]
      + w3[31:16] + w3[15:0] + w4[31:16] + w4[15:0];
    s = s[31:16] + s[15:0];
    s = s + (s >> 16);
    header_checksum = ~s[15:0];
  endfunction

  function automatic bit predict_route_result(input iprlf_pkg::req_t r,
                                              output iprlf_pkg::rsp_t o);
    logic [5:0]  len;
    logic [7:0]  ttl;
    logic [31:0] best_hop;
    logic [5:0]  best_len;
    bit          found;
    o = '0;
    case (r.cmd)
      iprlf_pkg::CMD_CLEAR: begin
        rt_count = 0;
        o.status = iprlf_pkg::STAT_CLEARED;
      end
      iprlf_pkg::CMD_ADD: begin
        if (rt_count >= iprlf_pkg::TABLE_DEPTH) begin
          o.status = iprlf_pkg::STAT_FULL;
        end else begin
          len = (r.route_mask_len > 6'd32) ? 6'd32 : r.route_mask_len;
          rt_prefix[rt_count] = r.route_prefix;
          rt_len[rt_count] = len;
          rt_hop[rt_count] = r.route_next_hop;
          rt_count++;
          o.status = iprlf_pkg::STAT_ADDED;
        end
      end
      iprlf_pkg::CMD_FORWARD: begin
        ttl = r.header_word_2[31:24];
        if (r.header_word_4 == node_addr) begin
          o.status = iprlf_pkg::STAT_LOCAL;
        end else if (ttl == 8'd0) begin
          o.status = iprlf_pkg::STAT_TTL_DROP;
        end else begin
          found = 1'b0;
          best_len = '0;
          best_hop = '0;
          for (int i = 0; i < rt_count; i++) begin
            if (((r.header_word_4 ^ rt_prefix[i]) & route_mask(rt_len[i])) == 32'h0 &&
                (!found || rt_len[i] > best_len)) begin
              found = 1'b1;
              best_len = rt_len[i];
              best_hop = rt_hop[i];
            end
          end
          if (!found) begin
            o.status = iprlf_pkg::STAT_NO_ROUTE;
          end else begin
            o.status = iprlf_pkg::STAT_FORWARD;
            o.next_hop = best_hop;
            o.new_ttl = ttl - 8'd1;
            o.new_checksum = header_checksum(r.header_word_0, r.header_word_1,
                                             {ttl - 8'd1, r.header_word_2[23:16], 16'h0},
                                             r.header_word_3, r.header_word_4);
          end
        end
      end
      default: return 1'b0;
    endcase
    status_seen[o.status]++;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want, got);
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    iprlf_pkg::rsp_t want;
    iprlf_pkg::rsp_t seen;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        seen = rsp;
        if (route_results_due.size() == 0) begin
          $error("response with no request outstanding: status %0d", seen.status);
          mismatches++;
        end else begin
          want = route_results_due.pop_front();
          if (seen.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(seen.status));
          if (seen.next_hop !== want.next_hop)
            note_mismatch("next_hop", want.next_hop, seen.next_hop);
          if (seen.new_ttl !== want.new_ttl)
            note_mismatch("new_ttl", 32'(want.new_ttl), 32'(seen.new_ttl));
          if (seen.new_checksum !== want.new_checksum)
            note_mismatch("new_checksum", 32'(want.new_checksum), 32'(seen.new_checksum));
        end
      end
      if (psel && penable && pwrite && pready && paddr == LOCAL_OFS)
        node_addr = pwdata;
      if (req_valid && req_ready && predict_route_result(req, want))
        route_results_due.insert(route_results_due.size(), cur_fixed ? cur_fixed_rsp : want);
    end
  end

  // Response side: random back-pressure, plus one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      rsp_ready = !gaps_on || ($urandom_range(99) >= 16);
    end
  end

  // All stimulus tasks start and end at a falling edge.
  task automatic send_cmd(input iprlf_pkg::req_t r, input bit fixed = 1'b0,
                          input iprlf_pkg::rsp_t fixed_rsp = '0);
    while (gaps_on && $urandom_range(99) < 16) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req = r;
    cur_fixed = fixed;
    cur_fixed_rsp = fixed_rsp;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    if (r.cmd == CMD_UNUSED)
      unused_sent++;
    else
      reqs_sent++;
  endtask

  task automatic wait_drained(input int extra);
    req_valid = 1'b0;
    while (route_results_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = LOCAL_OFS;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data) begin
      $error("local_address readback: expected 0x%0h, got 0x%0h", data, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_local_address(input logic [31:0] addr);
    wait_drained(SETTLE_CYCLES);
    apb_access(1'b1, addr);
    apb_access(1'b0, addr);
  endtask

  function automatic iprlf_pkg::req_t mk_add(input logic [31:0] prefix,
                                             input logic [5:0] len,
                                             input logic [31:0] hop);
    mk_add = '0;
    mk_add.cmd = iprlf_pkg::CMD_ADD;
    mk_add.route_prefix = prefix;
    mk_add.route_mask_len = len;
    mk_add.route_next_hop = hop;
  endfunction

  function automatic iprlf_pkg::req_t mk_fwd(input logic [31:0] w0, w1, w2, w3, w4);
    mk_fwd = '0;
    mk_fwd.cmd = iprlf_pkg::CMD_FORWARD;
    mk_fwd.header_word_0 = w0;
    mk_fwd.header_word_1 = w1;
    mk_fwd.header_word_2 = w2;
    mk_fwd.header_word_3 = w3;
    mk_fwd.header_word_4 = w4;
  endfunction

  function automatic iprlf_pkg::req_t mk_other(input logic [1:0] cmd, input logic [31:0] fill);
    mk_other = '{cmd, fill, fill[5:0], fill, fill, fill, fill, fill, fill};
  endfunction

  function automatic iprlf_pkg::rsp_t mk_rsp(input iprlf_pkg::status_t st,
                                             input logic [31:0] hop = '0,
                                             input logic [7:0] ttl = '0,
                                             input logic [15:0] csum = '0);
    mk_rsp = '{st, hop, ttl, csum};
  endfunction

  task automatic add_row(input iprlf_pkg::req_t r, input bit fixed = 1'b0,
                         input iprlf_pkg::rsp_t want = '0);
    directed.insert(directed.size(), dir_row_t'{r, fixed, want});
  endtask

  function automatic iprlf_pkg::req_t rand_add();
    int          roll;
    logic [5:0]  len;
    roll = $urandom_range(99);
    if (roll < 3)
      len = 6'd0;
    else if (roll < 8)
      len = 6'($urandom_range(63, 33));
    else
      len = 6'($urandom_range(32, 8));
    rand_add = mk_add($urandom, len, $urandom);
  endfunction

  function automatic iprlf_pkg::req_t rand_forward();
    int          roll;
    int          k;
    logic [31:0] m;
    logic [31:0] dst;
    logic [7:0]  ttl;
    roll = $urandom_range(99);
    if (roll < 10) begin
      dst = node_addr;
    end else if (roll < 25 || rt_count == 0) begin
      dst = $urandom;
    end else begin
      k = $urandom_range(rt_count - 1);
      m = route_mask(rt_len[k]);
      dst = (rt_prefix[k] & m) | ($urandom & ~m);
      if (roll < 35)
        dst ^= 32'h1 << $urandom_range(31);
    end
    roll = $urandom_range(99);
    if (roll < 5)
      ttl = 8'd0;
    else if (roll < 10)
      ttl = 8'd1;
    else if (roll < 15)
      ttl = 8'hFF;
    else
      ttl = 8'($urandom_range(255, 1));
    rand_forward = mk_fwd($urandom, $urandom, {ttl, 24'($urandom)}, $urandom, dst);
  endfunction

  function automatic iprlf_pkg::req_t rand_mixed();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4)
      rand_mixed = '{CMD_UNUSED, $urandom, 6'($urandom), $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
    else if (roll < 6)
      rand_mixed = mk_other(iprlf_pkg::CMD_CLEAR, $urandom);
    else if (roll < 10)
      rand_mixed = rand_add();
    else
      rand_mixed = rand_forward();
  endfunction

  initial begin
    #(8_000_000);
    $display("ipv4_route_lookup_forward_unit test failed");
    $finish;
  end

  initial begin
    int phase;
    int n_add;
    int n_fwd;
    int guard;

    // Empty table, local address zero after reset.
    add_row(mk_fwd(0, 0, 32'h4000_0000, 0, 32'h0A0A_0A0A), 1'b1,
            mk_rsp(iprlf_pkg::STAT_NO_ROUTE));
    add_row(mk_fwd('1, '1, 32'h00FF_FFFF, '1, 0), 1'b1, mk_rsp(iprlf_pkg::STAT_LOCAL));
    add_row(mk_fwd(0, 0, 32'h0011_2233, 0, '1), 1'b1, mk_rsp(iprlf_pkg::STAT_TTL_DROP));
    add_row(mk_other(CMD_UNUSED, 32'h5A5A_A5A5));
    add_row(mk_add('1, 6'd0, 32'h0A00_0001), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC0A8_0105, 6'd63, '1), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC0FF_FFFF, 6'd8, 32'h1111_1111), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC000_0000, 6'd8, 32'h2222_2222), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC0A8_01FF, 6'd24, 32'h3333_3333), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC0A8_0100, 6'd24, 32'h4444_4444), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(32'hC0A8_0100, 6'd24, 32'h4444_4444), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_add(0, 6'd32, 0), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_fwd(0, 0, 32'h0100_0000, 0, 1), 1'b1,
            mk_rsp(iprlf_pkg::STAT_FORWARD, 32'h0A00_0001, 8'd0, 16'hFFFE));
    add_row(mk_fwd(32'h4500_0054, 32'h1C46_4000, 32'hFF06_B1E6, 32'hAC10_0A63, 32'hC0A8_0105));
    add_row(mk_fwd(32'h4500_0030, 32'h0000_0000, 32'h0211_0000, 32'h0A00_0002, 32'hC0A8_0177));
    add_row(mk_fwd(32'h4500_0028, 32'hABCD_0000, 32'h4006_1234, 32'h0101_0101, 32'hC012_3456));
    add_row(mk_fwd('1, '1, '1, '1, '1));
    add_row(mk_fwd(0, 0, 32'hFF00_0000, 0, 0), 1'b1, mk_rsp(iprlf_pkg::STAT_LOCAL));
    add_row(mk_other(iprlf_pkg::CMD_CLEAR, 0), 1'b1, mk_rsp(iprlf_pkg::STAT_CLEARED));
    add_row(mk_fwd(0, 0, 32'h0900_0000, 0, 32'hC0A8_0105), 1'b1,
            mk_rsp(iprlf_pkg::STAT_NO_ROUTE));
    add_row(mk_other(CMD_UNUSED, '1));
    add_row(mk_add(32'h1234_5678, 6'd40, 32'h9ABC_DEF0), 1'b1, mk_rsp(iprlf_pkg::STAT_ADDED));
    add_row(mk_fwd(32'h4500_0014, 0, 32'h8001_0000, 32'hDEAD_BEEF, 32'h1234_5678));
    add_row(mk_fwd(32'h4500_0014, 0, 32'h8001_0000, 32'hDEAD_BEEF, 32'h1234_5679), 1'b1,
            mk_rsp(iprlf_pkg::STAT_NO_ROUTE));

    repeat (9) @(negedge clk);
    rst = 1'b0;
    apb_access(1'b0, 32'h0);

    foreach (directed[i])
      send_cmd(directed[i].r, directed[i].fixed, directed[i].want);

    phase = 0;
    while (reqs_sent < TARGET_REQS) begin
      case (phase % 4)
        0: set_local_address(32'hFFFF_FFFF);
        1: set_local_address(32'h0);
        default: set_local_address($urandom);
      endcase
      gaps_on = (phase != 3);
      if (phase == 1)
        hold_off_req = 1'b1;
      if (phase == 0 || $urandom_range(99) < 90)
        send_cmd(mk_other(iprlf_pkg::CMD_CLEAR, $urandom));
      if (phase == 0)
        n_add = iprlf_pkg::TABLE_DEPTH + 2;
      else if ($urandom_range(99) < 10)
        n_add = $urandom_range(70, 56);
      else
        n_add = $urandom_range(24, 1);
      repeat (n_add) send_cmd(rand_add());
      n_fwd = $urandom_range(50, 20);
      for (int i = 0; i < n_fwd; i++) begin
        if (phase == 2 && i == n_fwd / 2)
          wait_drained(0);
        send_cmd(phase == 0 ? rand_forward() : rand_mixed());
      end
      phase++;
    end

    req_valid = 1'b0;
    guard = 0;
    while (route_results_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (route_results_due.size() != 0) begin
      $error("%0d responses never arrived", route_results_due.size());
      mismatches++;
    end

    $display("Ran %0d commands, %0d unused, in %0d phases: %0d clears, %0d adds, %0d refused.",
             reqs_sent, unused_sent, phase, status_seen[iprlf_pkg::STAT_CLEARED],
             status_seen[iprlf_pkg::STAT_ADDED], status_seen[iprlf_pkg::STAT_FULL]);
    $display("Forwarded %0d, local %0d, dropped on TTL %0d, without a route %0d.",
             status_seen[iprlf_pkg::STAT_FORWARD], status_seen[iprlf_pkg::STAT_LOCAL],
             status_seen[iprlf_pkg::STAT_TTL_DROP], status_seen[iprlf_pkg::STAT_NO_ROUTE]);
    if (mismatches == 0)
      $display("ipv4_route_lookup_forward_unit test passed");
    else
      $display("ipv4_route_lookup_forward_unit test failed");
    $finish;
  end

endmodule
